[rtl/u16u8_pkg.sv]
package u16u8_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] HI_FIRST  = 16'hD800;
  localparam logic [15:0] HI_LAST   = 16'hDBFF;
  localparam logic [15:0] LO_FIRST  = 16'hDC00;
  localparam logic [15:0] LO_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [1:0] LEN_ONE   = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR  = 2'd3;

  // One queue entry: one or two code points, bytes of all of them end one run.
  typedef struct packed {
    logic [20:0] cp0;
    logic [1:0]  len0;
    logic        has1;
    logic [20:0] cp1;
    logic [1:0]  len1;
  } job_t;

  // Byte count minus one.
  function automatic logic [1:0] pt_len(input logic [20:0] c);
    logic [1:0] l;
    if (c[20:7] == 14'd0) begin
      l = LEN_ONE;
    end else if (c[20:11] == 10'd0) begin
      l = LEN_TWO;
    end else if (c[20:16] == 5'd0) begin
      l = LEN_THREE;
    end else begin
      l = LEN_FOUR;
    end
    return l;
  endfunction

  function automatic logic [7:0] enc_byte(input logic [20:0] c, input logic [1:0] lm1,
                                          input logic [1:0] idx);
    logic [7:0] b;
    b = {1'b0, c[6:0]};
    unique case (lm1)
      LEN_ONE: b = {1'b0, c[6:0]};
      LEN_TWO: begin
        if (idx == 2'd0) b = {3'b110, c[10:6]};
        else             b = {2'b10, c[5:0]};
      end
      LEN_THREE: begin
        unique case (idx)
          2'd0:    b = {4'b1110, c[15:12]};
          2'd1:    b = {2'b10, c[11:6]};
          default: b = {2'b10, c[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    b = {5'b11110, c[20:18]};
          2'd1:    b = {2'b10, c[17:12]};
          2'd2:    b = {2'b10, c[11:6]};
          default: b = {2'b10, c[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

[rtl/u16u8_front.sv]
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_code_unit,
  input  logic                in_string_end,
  input  logic                q_full,
  output logic                q_push,
  output u16u8_pkg::job_t     q_job
);

  logic        held_r, held_nxt;
  logic [15:0] held_unit_r, held_unit_nxt;
  logic        accept, is_low, is_high, hold_new;
  logic [20:0] unit_cp, held_cp, pair_cp;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_low   = (in_code_unit >= u16u8_pkg::LO_FIRST) && (in_code_unit <= u16u8_pkg::LO_LAST);
  assign is_high  = (in_code_unit >= u16u8_pkg::HI_FIRST) && (in_code_unit <= u16u8_pkg::HI_LAST);
  assign hold_new = is_high && !in_string_end;
  assign unit_cp  = {5'd0, in_code_unit};
  assign held_cp  = {5'd0, held_unit_r};
  assign pair_cp  = u16u8_pkg::SUPP_BASE + {1'b0, held_unit_r[9:0], in_code_unit[9:0]};

  always_comb begin
    q_job         = '0;
    q_push        = 1'b0;
    held_nxt      = held_r;
    held_unit_nxt = held_unit_r;
    if (accept) begin
      if (held_r && is_low) begin
        q_push      = 1'b1;
        q_job.cp0   = pair_cp;
        q_job.len0  = u16u8_pkg::pt_len(pair_cp);
        held_nxt    = 1'b0;
      end else if (held_r) begin
        q_push      = 1'b1;
        q_job.cp0   = held_cp;
        q_job.len0  = u16u8_pkg::pt_len(held_cp);
        q_job.has1  = !hold_new;
        q_job.cp1   = unit_cp;
        q_job.len1  = u16u8_pkg::pt_len(unit_cp);
        held_nxt    = hold_new;
      end else begin
        q_push      = !hold_new;
        q_job.cp0   = unit_cp;
        q_job.len0  = u16u8_pkg::pt_len(unit_cp);
        held_nxt    = hold_new;
      end
      if (hold_new) held_unit_nxt = in_code_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
    end
    held_unit_r <= held_unit_nxt;
  end

endmodule

[rtl/u16u8_fifo.sv]
module u16u8_fifo #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  u16u8_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output u16u8_pkg::job_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  u16u8_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) mem_r[wr_r] <= push_job;
  end

endmodule

[rtl/u16u8_back.sv]
module u16u8_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  u16u8_pkg::job_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_utf8_byte,
  output logic            out_run_last
);

  u16u8_pkg::job_t cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic       sel_r, sel_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       oval_r, oval_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       olast_r, olast_nxt;
  logic       advance, pt_done, job_done;
  logic [20:0] cp;
  logic [1:0]  lm1;

  assign cp       = sel_r ? cur_r.cp1 : cur_r.cp0;
  assign lm1      = sel_r ? cur_r.len1 : cur_r.len0;
  assign advance  = busy_r && (out_ready || !oval_r);
  assign pt_done  = (idx_r == lm1);
  assign job_done = pt_done && (sel_r || !cur_r.has1);
  assign q_pop    = !q_empty && (!busy_r || (advance && job_done));

  always_comb begin
    cur_nxt   = cur_r;
    busy_nxt  = busy_r;
    sel_nxt   = sel_r;
    idx_nxt   = idx_r;
    oval_nxt  = oval_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    if (out_ready) oval_nxt = 1'b0;
    if (advance) begin
      oval_nxt  = 1'b1;
      obyte_nxt = u16u8_pkg::enc_byte(cp, lm1, idx_r);
      olast_nxt = job_done;
      if (job_done) begin
        busy_nxt = 1'b0;
      end else if (pt_done) begin
        sel_nxt = 1'b1;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (q_pop) begin
      cur_nxt  = q_head;
      busy_nxt = 1'b1;
      sel_nxt  = 1'b0;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
      sel_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
      sel_r  <= sel_nxt;
      idx_r  <= idx_nxt;
    end
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid     = oval_r;
  assign out_utf8_byte = obyte_r;
  assign out_run_last  = olast_r;

endmodule

[rtl/utf16_to_utf8_encoder.sv]
// A first byte passes the queue, cur_r and obyte_r, in that order, before out_valid.
// Throughput: one output byte per cycle from the byte serializer while out_ready is
//   high and jobs are queued; one queue job yields up to 6 bytes.
// A held high surrogate yields nothing until the next unit arrives.
// Reset: rst_n synchronous, active low; clears the held surrogate, queue and output.
module utf16_to_utf8_encoder #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        in_string_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_utf8_byte,
  output logic        out_run_last
);

  logic            q_full, q_empty, q_push, q_pop;
  u16u8_pkg::job_t q_job, q_head;

  u16u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_code_unit  (in_code_unit),
    .in_string_end (in_string_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (q_job)
  );

  u16u8_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  u16u8_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_utf8_byte (out_utf8_byte),
    .out_run_last  (out_run_last)
  );

endmodule

[rtl/u16u8_checker.sv]
module u16u8_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_utf8_byte,
  input logic       out_run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_utf8_byte) && $stable(out_run_last))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_last_not_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last |-> out_utf8_byte[7:6] != 2'b11)
    else $error("run ends on a lead byte");

  a_legal_lead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_utf8_byte[7:3] != 5'b11111 && out_utf8_byte != 8'hC0 &&
                  out_utf8_byte != 8'hC1)
    else $error("illegal UTF-8 lead byte");

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_utf8_byte (out_utf8_byte),
  .out_run_last  (out_run_last)
);
